// ===== design/yuv2rgb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// shared types, widths, register indexes and coefficient tables for the
// yuv to rgb8 pixel converter
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    // pipeline depth: three adjust stages, three matrix stages
    localparam int NUM_STAGES = 6;

    localparam int SAMPLE_W  = 16;   // input sample width
    localparam int DIFF_W    = 17;   // sample minus pivot
    localparam int GAIN_W    = 8;    // gain register width
    localparam int PROD_W    = 26;   // difference times gain
    localparam int LEVEL_W   = 14;   // adjusted sample after depth reduction
    localparam int BIAS_W    = 14;   // luma offset / chroma zero
    localparam int CENT_W    = 15;   // centered sample, signed
    localparam int COEF_W    = 19;   // matrix coefficient, signed
    localparam int MPROD_W   = 34;   // centered sample times coefficient
    localparam int ACC_W     = 36;   // matrix row sum
    localparam int SHIFT_W   = 5;    // output shift amount
    localparam int RGB_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_SELECT = 3'd0,
        REG_FULL_RANGE    = 3'd1,
        REG_SAMPLE_BITS   = 3'd2,
        REG_LUMA_SCALE    = 3'd3,
        REG_LUMA_OFFSET   = 3'd4,
        REG_CHROMA_SCALE  = 3'd5,
        REG_CHROMA_OFFSET = 3'd6,
        REG_INVERT_FLAGS  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MATRIX_BT601  = 2'd0,
        MATRIX_BT709  = 2'd1,
        MATRIX_BT2020 = 2'd2,
        MATRIX_NONE   = 2'd3
    } matrix_t;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t cy;
        coef_t crv;
        coef_t cgu;
        coef_t cgv;
        coef_t cbu;
    } coef_set_t;

    // decoded settings seen by the datapath
    typedef struct packed {
        logic [SAMPLE_W-1:0] mask;
        logic                drop2;
        logic [BIAS_W-1:0]   y_bias;
        logic [BIAS_W-1:0]   c_bias;
        logic [SHIFT_W-1:0]  shift;
        logic [GAIN_W-1:0]   luma_scale;
        logic [SAMPLE_W-1:0] luma_offset;
        logic [GAIN_W-1:0]   chroma_scale;
        logic [SAMPLE_W-1:0] chroma_offset;
        logic                inv_y;
        logic                inv_c;
        coef_set_t           coefs;
    } cfg_t;

    function automatic coef_set_t coef_lookup(input logic [1:0] sel, input logic full);
        coef_set_t c;
        c = '0;
        if (full) begin
            unique case (matrix_t'(sel))
                MATRIX_BT601: begin
                    c = '{19'sd65536, 19'sd91881, -19'sd22553, -19'sd46802, 19'sd116129};
                end
                MATRIX_BT709: begin
                    c = '{19'sd65536, 19'sd103206, -19'sd12276, -19'sd30679, 19'sd121608};
                end
                MATRIX_BT2020: begin
                    c = '{19'sd65536, 19'sd96638, -19'sd10783, -19'sd37444, 19'sd123299};
                end
                default: begin
                    c = '0;
                end
            endcase
        end else begin
            unique case (matrix_t'(sel))
                MATRIX_BT601: begin
                    c = '{19'sd76309, 19'sd104597, -19'sd25675, -19'sd53279, 19'sd132201};
                end
                MATRIX_BT709: begin
                    c = '{19'sd76309, 19'sd117489, -19'sd13975, -19'sd34925, 19'sd138438};
                end
                MATRIX_BT2020: begin
                    c = '{19'sd76309, 19'sd110013, -19'sd12276, -19'sd42626, 19'sd140363};
                end
                default: begin
                    c = '0;
                end
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/yuv_to_rgb8_pixel_converter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb8_pixel_converter_core
// streaming ycbcr to 8-bit rgb converter with luma / chroma gain and inversion
// ----------------------------------------------------------------------------
// Converts one Y/Cb/Cr pixel of 8 to 16 bits per sample into saturated 8-bit
// R, G, B. It takes one pixel per clock unless a stalled output has filled
// the pipeline, holds no state between pixels, and passes each pixel through
// six register stages: sample minus pivot, gain multiply, clamp and
// centering, coefficient multiply, row sum, floor shift and saturation.
// Each stage advances independently when it is empty or its successor moves,
// so a stalled output fills the pipeline bubbles before s_ready drops, and up
// to six pixels are held in flight. Configuration is written through the cfg
// channel (index = register number, data in the low bits) and is always
// ready; registers must only be changed while no pixel is in flight.
// ----------------------------------------------------------------------------
module yuv_to_rgb8_pixel_converter_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [yuv2rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [yuv2rgb_pkg::CFG_DATA_W-1:0]   cfg_data,

    // pixel input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]     s_y_sample,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]     s_u_sample,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]     s_v_sample,

    // rgb output
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [yuv2rgb_pkg::RGB_W-1:0]             m_red,
    output logic [yuv2rgb_pkg::RGB_W-1:0]             m_green,
    output logic [yuv2rgb_pkg::RGB_W-1:0]             m_blue
);

    yuv2rgb_pkg::cfg_t                            cfg;
    logic [yuv2rgb_pkg::NUM_STAGES-1:0]           stage_en;
    logic signed [yuv2rgb_pkg::CENT_W-1:0]        y_cent;
    logic signed [yuv2rgb_pkg::CENT_W-1:0]        u_cent;
    logic signed [yuv2rgb_pkg::CENT_W-1:0]        v_cent;

    // register file and decode of depth-dependent constants
    yuv2rgb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage valid bits and advance enables
    yuv2rgb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .stage_en  (stage_en),
        .out_valid (m_valid)
    );

    // a transaction is taken whenever the first stage can load
    assign s_ready = stage_en[0];

    // luma adjust, stages 0..2
    yuv2rgb_adjust u_adj_y (
        .aclk     (aclk),
        .en       (stage_en[2:0]),
        .sample   (s_y_sample),
        .pivot    (cfg.luma_offset),
        .gain     (cfg.luma_scale),
        .inv      (cfg.inv_y),
        .mask     (cfg.mask),
        .drop2    (cfg.drop2),
        .bias     (cfg.y_bias),
        .centered (y_cent)
    );

    // chroma adjust, shared gain and pivot
    yuv2rgb_adjust u_adj_u (
        .aclk     (aclk),
        .en       (stage_en[2:0]),
        .sample   (s_u_sample),
        .pivot    (cfg.chroma_offset),
        .gain     (cfg.chroma_scale),
        .inv      (cfg.inv_c),
        .mask     (cfg.mask),
        .drop2    (cfg.drop2),
        .bias     (cfg.c_bias),
        .centered (u_cent)
    );

    yuv2rgb_adjust u_adj_v (
        .aclk     (aclk),
        .en       (stage_en[2:0]),
        .sample   (s_v_sample),
        .pivot    (cfg.chroma_offset),
        .gain     (cfg.chroma_scale),
        .inv      (cfg.inv_c),
        .mask     (cfg.mask),
        .drop2    (cfg.drop2),
        .bias     (cfg.c_bias),
        .centered (v_cent)
    );

    // color matrix, stages 3..5; last stage is the output register
    yuv2rgb_matrix u_matrix (
        .aclk   (aclk),
        .en     (stage_en[5:3]),
        .y_cent (y_cent),
        .u_cent (u_cent),
        .v_cent (v_cent),
        .coefs  (cfg.coefs),
        .shift  (cfg.shift),
        .red    (m_red),
        .green  (m_green),
        .blue   (m_blue)
    );

endmodule
`default_nettype wire

// ===== design/yuv2rgb_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv2rgb_cfg
// configuration registers and decode of depth, offsets, shift and matrix
// ----------------------------------------------------------------------------
module yuv2rgb_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [yuv2rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [yuv2rgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output yuv2rgb_pkg::cfg_t                         cfg
);

    logic [1:0]  matrix_select_reg;
    logic        full_range_reg;
    logic [4:0]  sample_bits_reg;
    logic [7:0]  luma_scale_reg;
    logic [15:0] luma_offset_reg;
    logic [7:0]  chroma_scale_reg;
    logic [15:0] chroma_offset_reg;
    logic [1:0]  invert_flags_reg;

    logic [4:0]  bits_c;
    logic [4:0]  eff;
    logic [2:0]  pow;
    logic        drop2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_select_reg <= 2'd1;
            full_range_reg    <= 1'b0;
            sample_bits_reg   <= 5'd8;
            luma_scale_reg    <= 8'd1;
            luma_offset_reg   <= 16'd0;
            chroma_scale_reg  <= 8'd1;
            chroma_offset_reg <= 16'd0;
            invert_flags_reg  <= 2'd0;
        end else if (cfg_valid) begin
            unique case (yuv2rgb_pkg::cfg_idx_t'(cfg_index))
                yuv2rgb_pkg::REG_MATRIX_SELECT: matrix_select_reg <= cfg_data[1:0];
                yuv2rgb_pkg::REG_FULL_RANGE:    full_range_reg    <= cfg_data[0];
                yuv2rgb_pkg::REG_SAMPLE_BITS:   sample_bits_reg   <= cfg_data[4:0];
                yuv2rgb_pkg::REG_LUMA_SCALE:    luma_scale_reg    <= cfg_data[7:0];
                yuv2rgb_pkg::REG_LUMA_OFFSET:   luma_offset_reg   <= cfg_data;
                yuv2rgb_pkg::REG_CHROMA_SCALE:  chroma_scale_reg  <= cfg_data[7:0];
                yuv2rgb_pkg::REG_CHROMA_OFFSET: chroma_offset_reg <= cfg_data;
                yuv2rgb_pkg::REG_INVERT_FLAGS:  invert_flags_reg  <= cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // depth clamped to 8..16, two lsbs dropped above 14
    always_comb begin
        if (sample_bits_reg < 5'd8) begin
            bits_c = 5'd8;
        end else if (sample_bits_reg > 5'd16) begin
            bits_c = 5'd16;
        end else begin
            bits_c = sample_bits_reg;
        end
        drop2 = (bits_c > 5'd14);
        eff   = drop2 ? (bits_c - 5'd2) : bits_c;
        pow   = 3'(eff - 5'd8);

        cfg.mask          = 16'((17'd1 << bits_c) - 17'd1);
        cfg.drop2         = drop2;
        cfg.y_bias        = full_range_reg ? 14'd0 : (14'd16 << pow);
        cfg.c_bias        = 14'd128 << pow;
        cfg.shift         = eff + 5'd8;
        cfg.luma_scale    = luma_scale_reg;
        cfg.luma_offset   = luma_offset_reg;
        cfg.chroma_scale  = chroma_scale_reg;
        cfg.chroma_offset = chroma_offset_reg;
        cfg.inv_y         = invert_flags_reg[0];
        cfg.inv_c         = invert_flags_reg[1];
        cfg.coefs         = yuv2rgb_pkg::coef_lookup(matrix_select_reg, full_range_reg);
    end

endmodule
`default_nettype wire

// ===== design/yuv2rgb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv2rgb_ctrl
// stage valid bits and per-stage advance enables with bubble collapsing
// ----------------------------------------------------------------------------
module yuv2rgb_ctrl (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    input  wire logic                                 out_ready,
    output logic [yuv2rgb_pkg::NUM_STAGES-1:0]        stage_en,
    output logic                                      out_valid
);

    localparam int N = yuv2rgb_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N:0]   en_chain;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        en_chain[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            en_chain[k] = ~valid_reg[k] | en_chain[k+1];
        end
        for (int k = 0; k < N; k++) begin
            if (en_chain[k]) begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en  = en_chain[N-1:0];
    assign out_valid = valid_reg[N-1];

endmodule
`default_nettype wire

// ===== design/yuv2rgb_adjust.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv2rgb_adjust
// three-stage gain / inversion around a pivot, clamp, depth reduction and
// centering of one sample
// ----------------------------------------------------------------------------
module yuv2rgb_adjust (
    input  wire logic                                     aclk,
    input  wire logic [2:0]                               en,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]         sample,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]         pivot,
    input  wire logic [yuv2rgb_pkg::GAIN_W-1:0]           gain,
    input  wire logic                                     inv,
    input  wire logic [yuv2rgb_pkg::SAMPLE_W-1:0]         mask,
    input  wire logic                                     drop2,
    input  wire logic [yuv2rgb_pkg::BIAS_W-1:0]           bias,
    output logic signed [yuv2rgb_pkg::CENT_W-1:0]         centered
);

    localparam int DW = yuv2rgb_pkg::DIFF_W;
    localparam int PW = yuv2rgb_pkg::PROD_W;
    localparam int SW = yuv2rgb_pkg::SAMPLE_W;
    localparam int LW = yuv2rgb_pkg::LEVEL_W;
    localparam int CW = yuv2rgb_pkg::CENT_W;

    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] diff_next;
    logic signed [DW-1:0] diff_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] sum;
    logic [SW-1:0]        clamped;
    logic [SW-1:0]        level;
    logic signed [CW-1:0] cent_next;
    logic signed [CW-1:0] cent_reg;

    // stage 0: masked sample minus pivot, optional negate
    always_comb begin
        diff      = $signed({1'b0, sample & mask}) - $signed({1'b0, pivot});
        diff_next = inv ? -diff : diff;
    end

    // stage 1: gain
    assign prod_next = diff_reg * $signed({1'b0, gain});

    // stage 2: pivot back, clamp, drop lsbs, center
    always_comb begin
        sum = prod_reg + $signed({{(PW - SW){1'b0}}, pivot});
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > $signed({{(PW - SW){1'b0}}, mask})) begin
            clamped = mask;
        end else begin
            clamped = sum[SW-1:0];
        end
        level     = drop2 ? {2'b00, clamped[SW-1:2]} : clamped;
        cent_next = $signed({1'b0, level[LW-1:0]}) - $signed({1'b0, bias});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            diff_reg <= diff_next;
        end
        if (en[1]) begin
            prod_reg <= prod_next;
        end
        if (en[2]) begin
            cent_reg <= cent_next;
        end
    end

    assign centered = cent_reg;

endmodule
`default_nettype wire

// ===== design/yuv2rgb_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv2rgb_matrix
// three-stage color matrix: products, row sums, floor shift and saturation
// ----------------------------------------------------------------------------
module yuv2rgb_matrix (
    input  wire logic                                     aclk,
    input  wire logic [2:0]                               en,
    input  wire logic signed [yuv2rgb_pkg::CENT_W-1:0]    y_cent,
    input  wire logic signed [yuv2rgb_pkg::CENT_W-1:0]    u_cent,
    input  wire logic signed [yuv2rgb_pkg::CENT_W-1:0]    v_cent,
    input  wire yuv2rgb_pkg::coef_set_t                   coefs,
    input  wire logic [yuv2rgb_pkg::SHIFT_W-1:0]          shift,
    output logic [yuv2rgb_pkg::RGB_W-1:0]                 red,
    output logic [yuv2rgb_pkg::RGB_W-1:0]                 green,
    output logic [yuv2rgb_pkg::RGB_W-1:0]                 blue
);

    localparam int MW = yuv2rgb_pkg::MPROD_W;
    localparam int AW = yuv2rgb_pkg::ACC_W;
    localparam int RW = yuv2rgb_pkg::RGB_W;

    logic signed [MW-1:0] p_y_next, p_rv_next, p_gu_next, p_gv_next, p_bu_next;
    logic signed [MW-1:0] p_y_reg, p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [AW-1:0] acc_r_next, acc_g_next, acc_b_next;
    logic signed [AW-1:0] acc_r_reg, acc_g_reg, acc_b_reg;
    logic signed [AW-1:0] sh_r, sh_g, sh_b;
    logic [RW-1:0]        red_next, green_next, blue_next;
    logic [RW-1:0]        red_reg, green_reg, blue_reg;

    function automatic logic [RW-1:0] sat8(input logic signed [AW-1:0] x);
        logic [RW-1:0] r;
        if (x < 0) begin
            r = '0;
        end else if (x > $signed(AW'(255))) begin
            r = '1;
        end else begin
            r = x[RW-1:0];
        end
        return r;
    endfunction

    // stage 3: one multiplier per coefficient
    assign p_y_next  = y_cent * coefs.cy;
    assign p_rv_next = v_cent * coefs.crv;
    assign p_gu_next = u_cent * coefs.cgu;
    assign p_gv_next = v_cent * coefs.cgv;
    assign p_bu_next = u_cent * coefs.cbu;

    // stage 4: row sums
    assign acc_r_next = AW'(p_y_reg) + AW'(p_rv_reg);
    assign acc_g_next = AW'(p_y_reg) + AW'(p_gu_reg) + AW'(p_gv_reg);
    assign acc_b_next = AW'(p_y_reg) + AW'(p_bu_reg);

    // stage 5: arithmetic shift rounds toward minus infinity, then saturate
    always_comb begin
        sh_r       = acc_r_reg >>> shift;
        sh_g       = acc_g_reg >>> shift;
        sh_b       = acc_b_reg >>> shift;
        red_next   = sat8(sh_r);
        green_next = sat8(sh_g);
        blue_next  = sat8(sh_b);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_y_reg  <= p_y_next;
            p_rv_reg <= p_rv_next;
            p_gu_reg <= p_gu_next;
            p_gv_reg <= p_gv_next;
            p_bu_reg <= p_bu_next;
        end
        if (en[1]) begin
            acc_r_reg <= acc_r_next;
            acc_g_reg <= acc_g_next;
            acc_b_reg <= acc_b_next;
        end
        if (en[2]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule
`default_nettype wire

// ===== sim/yuv_to_rgb8_pixel_converter_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// yuv_to_rgb8_pixel_converter_core_tb
// self-checking bench for the streaming yuv to rgb8 pixel converter: a queue
// fed driver offers pixels, an own fixed-point model predicts every rgb result
// at input acceptance, and a monitor compares each output transaction field by
// field while both sides idle and stall at random across register settings
// ----------------------------------------------------------------------------
module yuv_to_rgb8_pixel_converter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import yuv2rgb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // generous bound on the whole run
    localparam int LONG_HOLD    = 300;     // output hold-off used to fill the pipe
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_PIXELS = 34;
    localparam int MAX_REPORTS  = 100;     // keep the log short on a bad build

    // one input pixel as offered on the s_ side
    typedef struct packed {
        logic [SAMPLE_W-1:0] y;
        logic [SAMPLE_W-1:0] u;
        logic [SAMPLE_W-1:0] v;
    } yuv_pixel_t;

    // one output pixel as seen on the m_ side
    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
    } rgb_pixel_t;

    // shadow of the eight registers, at their written widths
    typedef struct packed {
        logic [1:0]  matrix_sel;
        logic        full_range;
        logic [4:0]  sample_bits;
        logic [7:0]  luma_scale;
        logic [15:0] luma_offset;
        logic [7:0]  chroma_scale;
        logic [15:0] chroma_offset;
        logic [1:0]  invert_flags;
    } conv_settings_t;

    // matrix weights: luma, cr to red, cb to green, cr to green, cb to blue
    typedef struct packed {
        int cy;
        int crv;
        int cgu;
        int cgv;
        int cbu;
    } matrix_coef_t;

    // clock, reset and dut inputs, all known from time zero
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MATRIX_SELECT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_y_sample = '0;
    logic [SAMPLE_W-1:0] s_u_sample = '0;
    logic [SAMPLE_W-1:0] s_v_sample = '0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [RGB_W-1:0] m_red;
    logic [RGB_W-1:0] m_green;
    logic [RGB_W-1:0] m_blue;

    // bench state
    yuv_pixel_t     pixel_q[$];          // pixels waiting to be offered
    rgb_pixel_t     rgb_expected_q[$];   // predicted results, oldest first
    yuv_pixel_t     offered_px;          // pixel currently on the s_ bus
    conv_settings_t settings;            // register values the dut now holds
    int             src_idle_pct   = 0;
    int             sink_stall_pct = 0;
    logic           sink_hold_arm  = 1'b0;
    int             sink_hold_left = 0;
    int             error_count    = 0;
    int unsigned    cycle_count    = 0;

    always #10 aclk = ~aclk;

    yuv_to_rgb8_pixel_converter_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_y_sample (s_y_sample),
        .s_u_sample (s_u_sample),
        .s_v_sample (s_v_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_red      (m_red),
        .m_green    (m_green),
        .m_blue     (m_blue)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // depth register is clamped to 8..16 before use
    function automatic int effective_depth(logic [4:0] bits);
        if (bits < 5'd8) begin
            return 8;
        end
        if (bits > 5'd16) begin
            return 16;
        end
        return int'(bits);
    endfunction

    function automatic matrix_coef_t pick_coefs(logic [1:0] sel, logic full);
        matrix_coef_t k;
        k = '0;
        case (matrix_t'(sel))
            MATRIX_BT601: begin
                if (full) k = '{65536, 91881, -22553, -46802, 116129};
                else      k = '{76309, 104597, -25675, -53279, 132201};
            end
            MATRIX_BT709: begin
                if (full) k = '{65536, 103206, -12276, -30679, 121608};
                else      k = '{76309, 117489, -13975, -34925, 138438};
            end
            MATRIX_BT2020: begin
                if (full) k = '{65536, 96638, -10783, -37444, 123299};
                else      k = '{76309, 110013, -12276, -42626, 140363};
            end
            default: begin
                k = '0;   // unused code, all weights zero
            end
        endcase
        return k;
    endfunction

    // gain and optional mirror around the pivot, exact in signed form, then clamp
    function automatic longint adjust_level(longint s, longint pivot, longint gain,
                                            logic inv, longint top);
        longint d;
        longint n;
        d = s - pivot;
        if (inv) begin
            d = -d;
        end
        n = d * gain + pivot;
        if (n < 0) begin
            n = 0;
        end
        if (n > top) begin
            n = top;
        end
        return n;
    endfunction

    function automatic logic [RGB_W-1:0] clip8(longint x);
        if (x < 0) begin
            return 8'd0;
        end
        if (x > 255) begin
            return 8'd255;
        end
        return x[7:0];
    endfunction

    function automatic rgb_pixel_t convert_pixel(yuv_pixel_t px, conv_settings_t cf);
        int           depth;
        int           eff;
        int           sh;
        longint       top;
        longint       y;
        longint       u;
        longint       v;
        longint       y_bias;
        longint       c_zero;
        longint       yt;
        longint       ut;
        longint       vt;
        matrix_coef_t k;
        rgb_pixel_t   o;
        depth = effective_depth(cf.sample_bits);
        top   = (longint'(1) << depth) - 1;
        y = adjust_level(longint'(px.y) & top, longint'(cf.luma_offset),
                         longint'(cf.luma_scale), cf.invert_flags[0], top);
        u = adjust_level(longint'(px.u) & top, longint'(cf.chroma_offset),
                         longint'(cf.chroma_scale), cf.invert_flags[1], top);
        v = adjust_level(longint'(px.v) & top, longint'(cf.chroma_offset),
                         longint'(cf.chroma_scale), cf.invert_flags[1], top);
        eff = depth;
        // deep samples lose two lsbs so the matrix works on at most 14 bits
        if (depth > 14) begin
            y   = y >>> 2;
            u   = u >>> 2;
            v   = v >>> 2;
            eff = depth - 2;
        end
        y_bias = cf.full_range ? longint'(0) : (longint'(16) << (eff - 8));
        c_zero = longint'(128) << (eff - 8);
        sh     = 16 + eff - 8;
        k      = pick_coefs(cf.matrix_sel, cf.full_range);
        yt = (y - y_bias) * k.cy;
        ut = u - c_zero;
        vt = v - c_zero;
        // arithmetic shift floors negative sums
        o.red   = clip8((yt + vt * k.crv) >>> sh);
        o.green = clip8((yt + ut * k.cgu + vt * k.cgv) >>> sh);
        o.blue  = clip8((yt + ut * k.cbu) >>> sh);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // sample near the pivot, anywhere in range, at a range edge, or fully random;
    // bits above the depth are always filled with noise
    function automatic logic [SAMPLE_W-1:0] pick_sample(int pivot, int gain, int depth);
        int top;
        int spread;
        int v;
        top    = (1 << depth) - 1;
        spread = (top + 1) / (2 * (gain + 1)) + 2;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = pivot + int'($urandom_range(0, 2 * spread)) - spread;
            2:       v = $urandom_range(0, top);
            default: v = ($urandom_range(0, 1) != 0) ? top : 0;
        endcase
        v = (v & top) | (int'($urandom) & ~top);
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [7:0] pick_gain();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'd1;
            4, 5, 6:    return 8'($urandom_range(2, 4));
            7:          return 8'd255;
            8:          return 8'($urandom_range(0, 255));
            default:    return 8'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_pivot(int depth);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'(1 << (depth - 1));
            3:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, (1 << depth) - 1));
        endcase
    endfunction

    function automatic conv_settings_t random_settings();
        conv_settings_t cf;
        int             depth;
        cf.matrix_sel    = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        cf.full_range    = 1'($urandom_range(0, 1));
        cf.sample_bits   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(8, 16));
        depth            = effective_depth(cf.sample_bits);
        cf.luma_scale    = pick_gain();
        cf.luma_offset   = pick_pivot(depth);
        cf.chroma_scale  = pick_gain();
        cf.chroma_offset = pick_pivot(depth);
        cf.invert_flags  = 2'($urandom_range(0, 3));
        return cf;
    endfunction

    task automatic report(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic queue_pixel(input int y, input int u, input int v);
        yuv_pixel_t px;
        px.y = y[SAMPLE_W-1:0];
        px.u = u[SAMPLE_W-1:0];
        px.v = v[SAMPLE_W-1:0];
        pixel_q.push_back(px);
    endtask

    // one register write transaction; bits above the field width carry noise
    task automatic write_reg(input cfg_idx_t idx, input int value, input int width);
        int pad;
        pad = ($urandom_range(0, 1) != 0) ? int'($urandom) : 0;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'((pad & ~((1 << width) - 1)) | value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input conv_settings_t cf);
        write_reg(REG_MATRIX_SELECT, int'(cf.matrix_sel), 2);
        write_reg(REG_FULL_RANGE, int'(cf.full_range), 1);
        write_reg(REG_SAMPLE_BITS, int'(cf.sample_bits), 5);
        write_reg(REG_LUMA_SCALE, int'(cf.luma_scale), 8);
        write_reg(REG_LUMA_OFFSET, int'(cf.luma_offset), 16);
        write_reg(REG_CHROMA_SCALE, int'(cf.chroma_scale), 8);
        write_reg(REG_CHROMA_OFFSET, int'(cf.chroma_offset), 16);
        write_reg(REG_INVERT_FLAGS, int'(cf.invert_flags), 2);
        settings = cf;
    endtask

    // idle until every queued pixel was taken and every result came back
    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_valid || rgb_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued pixels, predicts the result of each accepted one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // input transaction completes at this edge
            if (s_valid && s_ready) begin
                rgb_expected_q.push_back(convert_pixel(offered_px, settings));
            end
            // bus is free for a new pixel, or a random sender gap
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && int'($urandom_range(0, 99)) >= src_idle_pct) begin
                    offered_px = pixel_q.pop_front();
                    s_valid    <= 1'b1;
                    s_y_sample <= offered_px.y;
                    s_u_sample <= offered_px.u;
                    s_v_sample <= offered_px.v;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rgb_pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rgb_expected_q.size() == 0) begin
                    report($sformatf("result r=%0d g=%0d b=%0d with none predicted",
                                     m_red, m_green, m_blue));
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (m_red !== want.red)
                        report($sformatf("red got %0d want %0d", m_red, want.red));
                    if (m_green !== want.green)
                        report($sformatf("green got %0d want %0d", m_green, want.green));
                    if (m_blue !== want.blue)
                        report($sformatf("blue got %0d want %0d", m_blue, want.blue));
                end
            end
            // long hold-off wins over the random stall
            m_ready <= (sink_hold_left == 0) && (int'($urandom_range(0, 99)) >= sink_stall_pct);
        end
    end

    // output hold-off counter, armed for one cycle by the sequencer
    always @(posedge aclk) begin
        if (!aresetn) begin
            sink_hold_left <= 0;
        end else if (sink_hold_arm) begin
            sink_hold_left <= LONG_HOLD;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rgb_expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: reset, directed phases, random phases, final verdict
    // ------------------------------------------------------------------------
    initial begin
        conv_settings_t cf;
        int             depth;
        int             mode;

        // register values after reset
        settings = '{matrix_sel: 2'd1, full_range: 1'b0, sample_bits: 5'd8,
                     luma_scale: 8'd1, luma_offset: 16'd0, chroma_scale: 8'd1,
                     chroma_offset: 16'd0, invert_flags: 2'd0};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, no write yet; noise above the 8-bit depth
        queue_pixel(0, 0, 0);
        queue_pixel('hFFFF, 'hFFFF, 'hFFFF);
        queue_pixel(16, 128, 128);
        queue_pixel(235, 16, 240);
        queue_pixel('hAB10, 'h1280, 'h7F80);
        wait_drained();

        // bt601 full range at 16 bits: depth reduction and negative sums
        cf = '{2'd0, 1'b1, 5'd16, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
        apply_settings(cf);
        queue_pixel(0, 0, 0);
        queue_pixel('hFFFF, 'hFFFF, 'hFFFF);
        queue_pixel('hFFFF, 0, 'hFFFF);
        queue_pixel(0, 'hFFFF, 0);
        wait_drained();

        // bt2020 limited at 10 bits, unit gain passes samples through
        cf = '{2'd2, 1'b0, 5'd10, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
        apply_settings(cf);
        queue_pixel(64, 512, 512);
        queue_pixel(940, 960, 64);
        queue_pixel('hFC00 | 1023, 'h0400, 'hF800);
        wait_drained();

        // unused matrix code gives black
        cf = '{2'd3, 1'b0, 5'd12, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
        apply_settings(cf);
        queue_pixel(4095, 0, 4095);
        queue_pixel(100, 2000, 3000);
        wait_drained();

        // depth below 8 acts as 8
        cf = '{2'd1, 1'b1, 5'd3, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
        apply_settings(cf);
        queue_pixel(255, 0, 255);
        queue_pixel('h1234, 'h56F0, 'h9A0F);
        wait_drained();

        // depth above 16 acts as 16
        cf = '{2'd0, 1'b0, 5'd31, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
        apply_settings(cf);
        queue_pixel('hFFFF, 'h8000, 'h8000);
        queue_pixel('h1000, 'hFFFF, 0);
        wait_drained();

        // zero gain with pivots above the sample range
        cf = '{2'd1, 1'b0, 5'd8, 8'd0, 16'hFFFF, 8'd0, 16'd300, 2'd0};
        apply_settings(cf);
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        wait_drained();

        // both inversions with maximum gain at 15 bits
        cf = '{2'd2, 1'b1, 5'd15, 8'd255, 16'd16384, 8'd255, 16'd16384, 2'd3};
        apply_settings(cf);
        queue_pixel(16384, 16385, 16383);
        queue_pixel(0, 32767, 'hFFFF);
        queue_pixel(16390, 16380, 16384);
        wait_drained();

        // random phases, cycling through the idling patterns
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == 0) begin
                cf = '{2'd0, 1'b0, 5'd8, 8'd1, 16'd0, 8'd1, 16'd0, 2'd0};
            end else if (phase == 1) begin
                cf = '{2'd2, 1'b1, 5'd16, 8'd255, 16'hFFFF, 8'd255, 16'hFFFF, 2'd3};
            end else begin
                cf = random_settings();
            end
            apply_settings(cf);

            mode = phase % 4;
            case (mode)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase

            depth = effective_depth(cf.sample_bits);
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                queue_pixel(pick_sample(int'(cf.luma_offset), int'(cf.luma_scale), depth),
                            pick_sample(int'(cf.chroma_offset), int'(cf.chroma_scale), depth),
                            pick_sample(int'(cf.chroma_offset), int'(cf.chroma_scale), depth));
            end

            // first phase: hold the output while the sender keeps offering
            if (phase == 0) begin
                @(posedge aclk);
                sink_hold_arm <= 1'b1;
                @(posedge aclk);
                sink_hold_arm <= 1'b0;
            end
            wait_drained();
        end

        // let any stray result show up before the verdict
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (NUM_STAGES * 4) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
